/* src/twv_pkg.sv */
// ----------------------------------------------------------------------------
// twv_pkg
// shared constants, types and helpers for the trapped water volume block
// ----------------------------------------------------------------------------
package twv_pkg;

    localparam int MAX_ROWS    = 512;
    localparam int MAX_COLS    = 512;
    localparam int HEIGHT_BITS = 16;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int DR_W     = $clog2(MAX_ROWS + 1);
    localparam int DC_W     = $clog2(MAX_COLS + 1);
    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(CELL_CAP);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int KEY_W    = HEIGHT_BITS + ROW_W + COL_W;
    localparam int CELL_W   = HEIGHT_BITS + 1;
    localparam int SIZE_W   = 10;
    localparam int VOL_W    = 34;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W   = DR_W + DC_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

    typedef enum logic [1:0] {
        DIR_DOWN,
        DIR_UP,
        DIR_RIGHT,
        DIR_LEFT
    } dir_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_B_ADR,
        ST_B_CHK,
        ST_B_NEXT,
        ST_PU_START,
        ST_PU_UP,
        ST_PU_CMP,
        ST_PO_TOP,
        ST_PO_LAST,
        ST_PO_INIT,
        ST_PO_SD,
        ST_PO_K1,
        ST_PO_K2,
        ST_PO_CMP,
        ST_PO_FIN,
        ST_N_ADR,
        ST_N_CHK,
        ST_N_NEXT,
        ST_DONE
    } state_t;

    // cell memory entry: {visited, height}
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } cell_req_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } heap_req_t;

    function automatic logic [DR_W-1:0] clamp_rows(input logic [SIZE_W-1:0] v);
        logic [DR_W-1:0] r;
        if (v == '0)
            r = DR_W'(1);
        else if (int'(v) > MAX_ROWS)
            r = DR_W'(MAX_ROWS);
        else
            r = DR_W'(v);
        return r;
    endfunction

    function automatic logic [DC_W-1:0] clamp_cols(input logic [SIZE_W-1:0] v);
        logic [DC_W-1:0] r;
        if (v == '0)
            r = DC_W'(1);
        else if (int'(v) > MAX_COLS)
            r = DC_W'(MAX_COLS);
        else
            r = DC_W'(v);
        return r;
    endfunction

endpackage

/* src/twv_cell_mem.sv */
// ----------------------------------------------------------------------------
// twv_cell_mem
// height map with visited flag per cell, one write and one registered read
// ----------------------------------------------------------------------------
module twv_cell_mem (
    input  logic                            clk,
    input  twv_pkg::cell_req_t              req,
    output logic [twv_pkg::CELL_W-1:0]      rdata
);

    logic [twv_pkg::CELL_W-1:0] mem [twv_pkg::CELL_CAP];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

/* src/twv_heap_mem.sv */
// ----------------------------------------------------------------------------
// twv_heap_mem
// binary min-heap storage of {level, row, col} keys
// ----------------------------------------------------------------------------
module twv_heap_mem (
    input  logic                            clk,
    input  twv_pkg::heap_req_t              req,
    output logic [twv_pkg::KEY_W-1:0]       rdata
);

    logic [twv_pkg::KEY_W-1:0] mem [twv_pkg::CELL_CAP];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

/* src/trapped_water_volume_grid_core.sv */
// ----------------------------------------------------------------------------
// trapped_water_volume_grid_core
// priority-flood trapped water volume over a row-major height map
// ----------------------------------------------------------------------------
// load: one cell per cycle; the last cell starts the flood
// flood: per popped cell, set by the heap (one heap access per cycle, sift loops
//   of up to log2(cells) levels) and four neighbor checks
// output: after the last cell, the flood of the whole grid, then one result
// reset: control and sizes (512 x 512) cleared; memories are not cleared,
//   the visited flag of each cell is cleared as that cell is loaded
// ----------------------------------------------------------------------------
module trapped_water_volume_grid_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [twv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [twv_pkg::SIZE_W-1:0]          cfg_data,
    // input transaction
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [twv_pkg::HEIGHT_BITS-1:0]     cell_height,
    // output transaction
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [twv_pkg::VOL_W-1:0]           water_volume
);

    localparam int HB = twv_pkg::HEIGHT_BITS;
    localparam int RW = twv_pkg::ROW_W;
    localparam int CW = twv_pkg::COL_W;
    localparam int AW = twv_pkg::ADDR_W;
    localparam int NW = twv_pkg::CNT_W;
    localparam int KW = twv_pkg::KEY_W;
    localparam int VW = twv_pkg::VOL_W;

    // state and datapath registers
    twv_pkg::state_t            state_reg, state_next;
    logic [twv_pkg::SIZE_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [twv_pkg::SIZE_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [NW-1:0]              loaded_reg, loaded_next;
    logic [NW-1:0]              hcount_reg, hcount_next;
    logic [VW-1:0]              vol_reg, vol_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              kid_reg, kid_next;
    logic [KW-1:0]              key_reg, key_next;
    logic [KW-1:0]              top_reg, top_next;
    logic [KW-1:0]              last_reg, last_next;
    logic [KW-1:0]              kval_reg, kval_next;
    logic [RW-1:0]              br_reg, br_next;
    logic [CW-1:0]              bc_reg, bc_next;
    logic [RW-1:0]              nr_reg, nr_next;
    logic [CW-1:0]              nc_reg, nc_next;
    logic [AW-1:0]              caddr_reg, caddr_next;
    twv_pkg::dir_t              dir_reg, dir_next;
    logic                       ret_nb_reg, ret_nb_next;
    logic                       out_valid_reg, out_valid_next;
    logic [VW-1:0]              out_vol_reg, out_vol_next;

    // memories
    twv_pkg::cell_req_t         cell_req;
    twv_pkg::heap_req_t         heap_req;
    logic [twv_pkg::CELL_W-1:0] cell_rdata;
    logic [KW-1:0]              heap_rdata;

    // derived values
    logic [twv_pkg::DR_W-1:0]   rows_eff;
    logic [twv_pkg::DC_W-1:0]   cols_eff;
    logic [NW-1:0]              total_cells;
    logic                       in_fire;
    logic [HB-1:0]              top_lvl;
    logic [RW-1:0]              top_r;
    logic [CW-1:0]              top_c;
    logic [RW-1:0]              nb_r;
    logic [CW-1:0]              nb_c;
    logic                       nb_ok;
    logic [AW-1:0]              nb_addr;
    logic [AW-1:0]              bd_addr;
    logic [NW-1:0]              kid_w;
    logic [NW-1:0]              kid_inc;
    logic                       b_last_col;
    logic                       b_last_row;
    logic                       b_edge_row;
    logic [HB-1:0]              cell_h;
    logic                       cell_vis;
    logic [HB-1:0]              nb_level;
    logic [VW:0]                vol_sum;
    logic [AW-1:0]              parent_pos;
    twv_pkg::state_t            ret_state;

    twv_cell_mem u_cell_mem (
        .clk   (clk),
        .req   (cell_req),
        .rdata (cell_rdata)
    );

    twv_heap_mem u_heap_mem (
        .clk   (clk),
        .req   (heap_req),
        .rdata (heap_rdata)
    );

    assign rows_eff    = twv_pkg::clamp_rows(rows_cfg_reg);
    assign cols_eff    = twv_pkg::clamp_cols(cols_cfg_reg);
    assign total_cells = NW'(rows_eff * cols_eff);

    assign in_stall     = (state_reg != twv_pkg::ST_LOAD);
    assign in_fire      = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign water_volume = out_vol_reg;

    // popped key fields
    assign top_lvl = top_reg[KW-1 -: HB];
    assign top_r   = top_reg[RW+CW-1 -: RW];
    assign top_c   = top_reg[CW-1:0];

    // neighbor of the popped cell in the current direction
    always_comb
    begin
        nb_r  = top_r;
        nb_c  = top_c;
        nb_ok = 1'b0;
        case (dir_reg)
            twv_pkg::DIR_DOWN:
            begin
                nb_r  = top_r + RW'(1);
                nb_ok = (twv_pkg::DR_W'(top_r) + twv_pkg::DR_W'(1)) < rows_eff;
            end
            twv_pkg::DIR_UP:
            begin
                nb_r  = top_r - RW'(1);
                nb_ok = (top_r != '0);
            end
            twv_pkg::DIR_RIGHT:
            begin
                nb_c  = top_c + CW'(1);
                nb_ok = (twv_pkg::DC_W'(top_c) + twv_pkg::DC_W'(1)) < cols_eff;
            end
            twv_pkg::DIR_LEFT:
            begin
                nb_c  = top_c - CW'(1);
                nb_ok = (top_c != '0);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // row-major addresses
    assign nb_addr = AW'(nb_r * cols_eff + twv_pkg::PROD_W'(nb_c));
    assign bd_addr = AW'(br_reg * cols_eff + twv_pkg::PROD_W'(bc_reg));

    // border walk: full edge rows, only the two end cells elsewhere
    assign b_last_col = (twv_pkg::DC_W'(bc_reg) == cols_eff - twv_pkg::DC_W'(1));
    assign b_last_row = (twv_pkg::DR_W'(br_reg) == rows_eff - twv_pkg::DR_W'(1));
    assign b_edge_row = (br_reg == '0) || b_last_row;

    // heap index helpers
    assign kid_w      = {pos_reg, 1'b1};
    assign kid_inc    = NW'(kid_reg) + NW'(1);
    assign parent_pos = (pos_reg - AW'(1)) >> 1;

    // cell read data and water level of a fresh neighbor
    assign cell_h   = cell_rdata[HB-1:0];
    assign cell_vis = cell_rdata[HB];
    assign nb_level = (cell_h < top_lvl) ? top_lvl : cell_h;
    assign vol_sum  = {1'b0, vol_reg} + (VW + 1)'(top_lvl - cell_h);

    assign ret_state = ret_nb_reg ? twv_pkg::ST_N_NEXT : twv_pkg::ST_B_NEXT;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twv_pkg::ST_LOAD:
            begin
                if (in_fire && (loaded_reg + NW'(1) >= total_cells))
                    state_next = twv_pkg::ST_B_ADR;
            end
            twv_pkg::ST_B_ADR:    state_next = twv_pkg::ST_B_CHK;
            twv_pkg::ST_B_CHK:    state_next = twv_pkg::ST_PU_START;
            twv_pkg::ST_B_NEXT:
            begin
                if (b_last_col && b_last_row)
                    state_next = twv_pkg::ST_PO_TOP;
                else
                    state_next = twv_pkg::ST_B_ADR;
            end
            twv_pkg::ST_PU_START: state_next = twv_pkg::ST_PU_UP;
            twv_pkg::ST_PU_UP:
            begin
                if (pos_reg == '0)
                    state_next = ret_state;
                else
                    state_next = twv_pkg::ST_PU_CMP;
            end
            twv_pkg::ST_PU_CMP:
            begin
                if (heap_rdata <= key_reg)
                    state_next = ret_state;
                else
                    state_next = twv_pkg::ST_PU_UP;
            end
            twv_pkg::ST_PO_TOP:   state_next = twv_pkg::ST_PO_LAST;
            twv_pkg::ST_PO_LAST:  state_next = twv_pkg::ST_PO_INIT;
            twv_pkg::ST_PO_INIT:  state_next = twv_pkg::ST_PO_SD;
            twv_pkg::ST_PO_SD:
            begin
                if (kid_w >= hcount_reg)
                    state_next = twv_pkg::ST_PO_FIN;
                else
                    state_next = twv_pkg::ST_PO_K1;
            end
            twv_pkg::ST_PO_K1:
            begin
                if (kid_inc < hcount_reg)
                    state_next = twv_pkg::ST_PO_K2;
                else
                    state_next = twv_pkg::ST_PO_CMP;
            end
            twv_pkg::ST_PO_K2:    state_next = twv_pkg::ST_PO_CMP;
            twv_pkg::ST_PO_CMP:
            begin
                if (kval_reg >= last_reg)
                    state_next = twv_pkg::ST_PO_FIN;
                else
                    state_next = twv_pkg::ST_PO_SD;
            end
            twv_pkg::ST_PO_FIN:   state_next = twv_pkg::ST_N_ADR;
            twv_pkg::ST_N_ADR:
            begin
                if (nb_ok)
                    state_next = twv_pkg::ST_N_CHK;
                else
                    state_next = twv_pkg::ST_N_NEXT;
            end
            twv_pkg::ST_N_CHK:
            begin
                if (cell_vis)
                    state_next = twv_pkg::ST_N_NEXT;
                else
                    state_next = twv_pkg::ST_PU_START;
            end
            twv_pkg::ST_N_NEXT:
            begin
                if (dir_reg != twv_pkg::DIR_LEFT)
                    state_next = twv_pkg::ST_N_ADR;
                else if (hcount_reg != '0)
                    state_next = twv_pkg::ST_PO_TOP;
                else
                    state_next = twv_pkg::ST_DONE;
            end
            twv_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                    state_next = twv_pkg::ST_LOAD;
            end
            default:              state_next = twv_pkg::ST_LOAD;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        rows_cfg_next  = rows_cfg_reg;
        cols_cfg_next  = cols_cfg_reg;
        loaded_next    = loaded_reg;
        hcount_next    = hcount_reg;
        vol_next       = vol_reg;
        pos_next       = pos_reg;
        kid_next       = kid_reg;
        key_next       = key_reg;
        top_next       = top_reg;
        last_next      = last_reg;
        kval_next      = kval_reg;
        br_next        = br_reg;
        bc_next        = bc_reg;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        caddr_next     = caddr_reg;
        dir_next       = dir_reg;
        ret_nb_next    = ret_nb_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_vol_next   = out_vol_reg;
        cell_req       = '0;
        heap_req       = '0;

        case (state_reg)
            twv_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    // store height and clear the visited flag of this cell
                    cell_req.we    = 1'b1;
                    cell_req.waddr = loaded_reg[AW-1:0];
                    cell_req.wdata = {1'b0, cell_height};
                    if (loaded_reg + NW'(1) >= total_cells)
                    begin
                        loaded_next = '0;
                        hcount_next = '0;
                        vol_next    = '0;
                        br_next     = '0;
                        bc_next     = '0;
                    end
                    else
                    begin
                        loaded_next = loaded_reg + NW'(1);
                    end
                end
            end
            twv_pkg::ST_B_ADR:
            begin
                cell_req.raddr = bd_addr;
                caddr_next     = bd_addr;
            end
            twv_pkg::ST_B_CHK:
            begin
                cell_req.we    = 1'b1;
                cell_req.waddr = caddr_reg;
                cell_req.wdata = {1'b1, cell_h};
                key_next       = {cell_h, br_reg, bc_reg};
                ret_nb_next    = 1'b0;
            end
            twv_pkg::ST_B_NEXT:
            begin
                if (b_last_col)
                begin
                    br_next = br_reg + RW'(1);
                    bc_next = '0;
                end
                else if (b_edge_row)
                begin
                    bc_next = bc_reg + CW'(1);
                end
                else
                begin
                    bc_next = CW'(cols_eff - twv_pkg::DC_W'(1));
                end
            end
            twv_pkg::ST_PU_START:
            begin
                pos_next    = hcount_reg[AW-1:0];
                hcount_next = hcount_reg + NW'(1);
            end
            twv_pkg::ST_PU_UP:
            begin
                if (pos_reg == '0)
                begin
                    heap_req.we    = 1'b1;
                    heap_req.waddr = pos_reg;
                    heap_req.wdata = key_reg;
                end
                else
                begin
                    heap_req.raddr = parent_pos;
                end
            end
            twv_pkg::ST_PU_CMP:
            begin
                heap_req.we    = 1'b1;
                heap_req.waddr = pos_reg;
                if (heap_rdata <= key_reg)
                begin
                    heap_req.wdata = key_reg;
                end
                else
                begin
                    // parent moves down one level
                    heap_req.wdata = heap_rdata;
                    pos_next       = parent_pos;
                end
            end
            twv_pkg::ST_PO_TOP:
            begin
                heap_req.raddr = '0;
            end
            twv_pkg::ST_PO_LAST:
            begin
                heap_req.raddr = AW'(hcount_reg - NW'(1));
                top_next       = heap_rdata;
            end
            twv_pkg::ST_PO_INIT:
            begin
                last_next   = heap_rdata;
                hcount_next = hcount_reg - NW'(1);
                pos_next    = '0;
            end
            twv_pkg::ST_PO_SD:
            begin
                if (kid_w < hcount_reg)
                begin
                    heap_req.raddr = kid_w[AW-1:0];
                    kid_next       = kid_w[AW-1:0];
                end
            end
            twv_pkg::ST_PO_K1:
            begin
                kval_next = heap_rdata;
                if (kid_inc < hcount_reg)
                    heap_req.raddr = kid_inc[AW-1:0];
            end
            twv_pkg::ST_PO_K2:
            begin
                if (heap_rdata < kval_reg)
                begin
                    kval_next = heap_rdata;
                    kid_next  = kid_inc[AW-1:0];
                end
            end
            twv_pkg::ST_PO_CMP:
            begin
                if (kval_reg < last_reg)
                begin
                    heap_req.we    = 1'b1;
                    heap_req.waddr = pos_reg;
                    heap_req.wdata = kval_reg;
                    pos_next       = kid_reg;
                end
            end
            twv_pkg::ST_PO_FIN:
            begin
                if (hcount_reg != '0)
                begin
                    heap_req.we    = 1'b1;
                    heap_req.waddr = pos_reg;
                    heap_req.wdata = last_reg;
                end
                dir_next = twv_pkg::DIR_DOWN;
            end
            twv_pkg::ST_N_ADR:
            begin
                cell_req.raddr = nb_addr;
                caddr_next     = nb_addr;
                nr_next        = nb_r;
                nc_next        = nb_c;
            end
            twv_pkg::ST_N_CHK:
            begin
                if (!cell_vis)
                begin
                    cell_req.we    = 1'b1;
                    cell_req.waddr = caddr_reg;
                    cell_req.wdata = {1'b1, cell_h};
                    key_next       = {nb_level, nr_reg, nc_reg};
                    ret_nb_next    = 1'b1;
                    // water above a lower neighbor, saturating
                    if (cell_h < top_lvl)
                    begin
                        if (vol_sum[VW])
                            vol_next = '1;
                        else
                            vol_next = vol_sum[VW-1:0];
                    end
                end
            end
            twv_pkg::ST_N_NEXT:
            begin
                dir_next = twv_pkg::dir_t'(dir_reg + 2'd1);
            end
            twv_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_vol_next   = vol_reg;
                end
            end
            default:
            begin
                loaded_next = '0;
            end
        endcase

        // size writes restart the grid
        if (cfg_we)
        begin
            loaded_next = '0;
            case (cfg_index)
                twv_pkg::REG_ROWS: rows_cfg_next = cfg_data;
                twv_pkg::REG_COLS: cols_cfg_next = cfg_data;
                default:           rows_cfg_next = rows_cfg_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twv_pkg::ST_LOAD;
            rows_cfg_reg  <= twv_pkg::SIZE_W'(512);
            cols_cfg_reg  <= twv_pkg::SIZE_W'(512);
            loaded_reg    <= '0;
            hcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            dir_reg       <= twv_pkg::DIR_DOWN;
            ret_nb_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            loaded_reg    <= loaded_next;
            hcount_reg    <= hcount_next;
            out_valid_reg <= out_valid_next;
            dir_reg       <= dir_next;
            ret_nb_reg    <= ret_nb_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vol_reg     <= vol_next;
        pos_reg     <= pos_next;
        kid_reg     <= kid_next;
        key_reg     <= key_next;
        top_reg     <= top_next;
        last_reg    <= last_next;
        kval_reg    <= kval_next;
        br_reg      <= br_next;
        bc_reg      <= bc_next;
        nr_reg      <= nr_next;
        nc_reg      <= nc_next;
        caddr_reg   <= caddr_next;
        out_vol_reg <= out_vol_next;
    end

endmodule
